// ----- sv/nfcwm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfcwm_pkg
// Shared types and constants for the wake detector and card identifier matcher.
// ----------------------------------------------------------------------------
package nfcwm_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned UID_W     = 32;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned WIN_DEPTH = 7;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned FRAME_LEN_DEF  = 25;
    localparam int unsigned UID_OFFSET_DEF = 19;

    localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_FF   = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_D5   = 8'hD5;
    localparam logic [BYTE_W-1:0] BYTE_14   = 8'h14;

    localparam logic [UID_W-1:0] KNOWN_A_RST = 32'h25F74806;
    localparam logic [UID_W-1:0] KNOWN_B_RST = 32'h5084FC23;
    localparam logic [UID_W-1:0] KNOWN_C_RST = 32'h40748023;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KNOWN_A = 2'd0,
        CFG_KNOWN_B = 2'd1,
        CFG_KNOWN_C = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             done;
        logic             matched;
        logic             seen;
        logic [UID_W-1:0] uid;
    } t_frame_res;

endpackage
`default_nettype wire

// ----- sv/nfc_wake_and_card_uid_matcher.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfc_wake_and_card_uid_matcher
// Wake detector and card identifier matcher for a card reader byte stream.
// ----------------------------------------------------------------------------
// Takes one received byte per clock while o_ready is high and returns one
// result word per byte from an output register in the next cycle; a new
// byte is taken in the same cycle the held result is taken. Before waking,
// bytes shift through a row of seven window cells that is compared against
// the wake acknowledgement and wake response; after waking, a frame counter
// captures the identifier and compares it with the three known identifiers
// at the last byte of each frame. Awake is cleared only by reset.
// ----------------------------------------------------------------------------
module nfc_wake_and_card_uid_matcher #(
    parameter int unsigned FRAME_LEN  = nfcwm_pkg::FRAME_LEN_DEF,
    parameter int unsigned UID_OFFSET = nfcwm_pkg::UID_OFFSET_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [nfcwm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [nfcwm_pkg::UID_W-1:0]     i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [nfcwm_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic                                 o_awake,
    output logic                                 o_frame_done,
    output logic                                 o_frame_matched,
    output logic                                 o_card_seen,
    output logic [nfcwm_pkg::UID_W-1:0]          o_card_uid
);

    localparam int unsigned DEPTH = nfcwm_pkg::WIN_DEPTH;

    logic [nfcwm_pkg::UID_W-1:0]  r_known_a;
    logic [nfcwm_pkg::UID_W-1:0]  r_known_b;
    logic [nfcwm_pkg::UID_W-1:0]  r_known_c;

    logic                         r_awake;
    logic                         n_awake;
    logic                         r_valid;
    logic                         n_valid;
    nfcwm_pkg::t_frame_res        r_res;
    logic                         r_out_awake;

    logic                         accept;
    logic                         shift;
    logic                         wake;
    logic                         head;
    logic                         ack;
    logic                         resp;
    logic [nfcwm_pkg::BYTE_W-1:0] win   [DEPTH];
    logic [nfcwm_pkg::BYTE_W-1:0] win_n [DEPTH];
    nfcwm_pkg::t_frame_res        res;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign shift   = accept && !r_awake;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known_a <= nfcwm_pkg::KNOWN_A_RST;
            r_known_b <= nfcwm_pkg::KNOWN_B_RST;
            r_known_c <= nfcwm_pkg::KNOWN_C_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nfcwm_pkg::CFG_KNOWN_A: r_known_a <= i_cfg_data;
                nfcwm_pkg::CFG_KNOWN_B: r_known_b <= i_cfg_data;
                nfcwm_pkg::CFG_KNOWN_C: r_known_c <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_win
        if (k == DEPTH - 1) begin : g_tail
            assign win_n[k] = i_rx_byte;
        end else begin : g_body
            assign win_n[k] = win[k+1];
        end
        nfcwm_win_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_byte  (win_n[k]),
            .o_byte  (win[k])
        );
    end

    always_comb begin
        head = (win_n[0] == nfcwm_pkg::BYTE_ZERO) && (win_n[1] == nfcwm_pkg::BYTE_ZERO)
            && (win_n[2] == nfcwm_pkg::BYTE_FF);
        ack  = head && (win_n[3] == nfcwm_pkg::BYTE_ZERO) && (win_n[4] == nfcwm_pkg::BYTE_FF)
            && (win_n[5] == nfcwm_pkg::BYTE_ZERO);
        resp = head && (win_n[5] == nfcwm_pkg::BYTE_D5) && (win_n[6] == nfcwm_pkg::BYTE_14);
        wake = ack || resp;
        n_awake = r_awake || (shift && wake);
        n_valid = accept || (r_valid && !i_ready);
    end

    nfcwm_frame #(
        .FRAME_LEN  (FRAME_LEN),
        .UID_OFFSET (UID_OFFSET)
    ) u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (accept && r_awake),
        .i_rx_byte (i_rx_byte),
        .i_known_a (r_known_a),
        .i_known_b (r_known_b),
        .i_known_c (r_known_c),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awake <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_awake <= n_awake;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res       <= res;
            r_out_awake <= n_awake;
        end
    end

    assign o_valid         = r_valid;
    assign o_awake         = r_out_awake;
    assign o_frame_done    = r_res.done;
    assign o_frame_matched = r_res.matched;
    assign o_card_seen     = r_res.seen;
    assign o_card_uid      = r_res.uid;

`ifndef SYNTHESIS
    a_awake_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awake |=> r_awake)
        else $error("awake dropped without reset");
    a_match_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_frame_matched) |-> o_frame_done)
        else $error("match reported without frame end");
    a_done_needs_awake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_frame_done) |-> o_awake)
        else $error("frame end reported while not awake");
    a_window_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awake |=> $stable(win[DEPTH-1]))
        else $error("window shifted while awake");
`endif

endmodule
`default_nettype wire

// ----- sv/nfcwm_win_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfcwm_win_cell
// One byte of the wake window; loads its neighbor's or the new byte on shift.
// ----------------------------------------------------------------------------
module nfcwm_win_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_shift,
    input  wire logic [nfcwm_pkg::BYTE_W-1:0] i_byte,
    output logic      [nfcwm_pkg::BYTE_W-1:0] o_byte
);

    logic [nfcwm_pkg::BYTE_W-1:0] r_byte;
    logic [nfcwm_pkg::BYTE_W-1:0] n_byte;

    always_comb begin
        n_byte = i_shift ? i_byte : r_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= nfcwm_pkg::BYTE_ZERO;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule
`default_nettype wire

// ----- sv/nfcwm_frame.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfcwm_frame
// Frame byte counter, identifier capture and known identifier compare.
// ----------------------------------------------------------------------------
module nfcwm_frame #(
    parameter int unsigned FRAME_LEN  = nfcwm_pkg::FRAME_LEN_DEF,
    parameter int unsigned UID_OFFSET = nfcwm_pkg::UID_OFFSET_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire logic [nfcwm_pkg::BYTE_W-1:0] i_rx_byte,
    input  wire logic [nfcwm_pkg::UID_W-1:0]  i_known_a,
    input  wire logic [nfcwm_pkg::UID_W-1:0]  i_known_b,
    input  wire logic [nfcwm_pkg::UID_W-1:0]  i_known_c,
    output nfcwm_pkg::t_frame_res             o_res
);

    localparam int unsigned CNT_W = nfcwm_pkg::CNT_W;

    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic [nfcwm_pkg::UID_W-1:0] r_capture;
    logic [nfcwm_pkg::UID_W-1:0] n_capture;
    logic [nfcwm_pkg::UID_W-1:0] r_last;
    logic [nfcwm_pkg::UID_W-1:0] n_last;
    logic                        r_seen;
    logic                        n_seen;

    logic                        in_uid;
    logic [CNT_W-1:0]            uid_off;
    logic [1:0]                  lane;
    logic [CNT_W-1:0]            pos_inc;
    logic                        done;
    logic                        matched;

    always_comb begin
        in_uid  = ({1'b0, r_count} >= (CNT_W+1)'(UID_OFFSET))
               && ({1'b0, r_count} <  (CNT_W+1)'(UID_OFFSET + 4));
        uid_off = r_count - CNT_W'(UID_OFFSET);
        lane    = 2'd3 - uid_off[1:0];
        pos_inc = r_count + CNT_W'(1);
        done    = i_step && (pos_inc >= CNT_W'(FRAME_LEN));

        n_capture = r_capture;
        if (i_step && in_uid) begin
            n_capture[{lane, 3'b000} +: nfcwm_pkg::BYTE_W] =
                r_capture[{lane, 3'b000} +: nfcwm_pkg::BYTE_W] | i_rx_byte;
        end

        n_last  = done ? n_capture : r_last;
        matched = done && ((n_last == i_known_a) || (n_last == i_known_b)
                        || (n_last == i_known_c));
        n_seen  = r_seen | matched;

        n_count = r_count;
        if (i_step) begin
            n_count = done ? '0 : pos_inc;
        end
        if (done) begin
            n_capture = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_capture <= '0;
            r_last    <= '0;
            r_seen    <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_capture <= n_capture;
            r_last    <= n_last;
            r_seen    <= n_seen;
        end
    end

    always_comb begin
        o_res.done    = done;
        o_res.matched = matched;
        o_res.seen    = n_seen;
        o_res.uid     = n_last;
    end

`ifndef SYNTHESIS
    a_count_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(FRAME_LEN))
        else $error("frame count past frame length");
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (r_count == '0) && (r_capture == '0))
        else $error("frame end did not restart count and capture");
    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |=> r_seen)
        else $error("seen flag dropped");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_nfc_wake_and_card_uid_matcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nfc_wake_and_card_uid_matcher
// Self-checking bench for the wake detector and card identifier matcher.
// ----------------------------------------------------------------------------
// Feeds reader bytes on the valid/ready input, first near-miss and stray wake
// sequences, then a real wake if asleep, then frames carrying known, near-miss
// and random identifiers mixed with loose bytes. A scoreboard class predicts
// one result word per accepted byte and compares every field of each result
// word. The known identifiers are reloaded between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_nfc_wake_and_card_uid_matcher;

    localparam int unsigned CLK_HALF    = 5;
    localparam int unsigned RESET_CYC   = 8;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned BYTE_TARGET = 1400;
    localparam int unsigned IDLE_PCT    = 35;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned TAIL_CYC    = 4;

    localparam logic [nfcwm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef logic [nfcwm_pkg::BYTE_W-1:0] t_rx_byte;
    typedef logic [nfcwm_pkg::UID_W-1:0]  t_uid;

    typedef struct packed {
        logic                  awake;
        nfcwm_pkg::t_frame_res res;
    } t_result;

    localparam t_rx_byte WAKE_FILL [8] = '{
        nfcwm_pkg::BYTE_ZERO, nfcwm_pkg::BYTE_ZERO, nfcwm_pkg::BYTE_FF,
        nfcwm_pkg::BYTE_ZERO, nfcwm_pkg::BYTE_FF, nfcwm_pkg::BYTE_ZERO,
        nfcwm_pkg::BYTE_D5, nfcwm_pkg::BYTE_14};

    class uid_scoreboard;
        t_uid        known [3];
        t_rx_byte    window [nfcwm_pkg::WIN_DEPTH];
        bit          awake;
        int unsigned count;
        t_uid        capture;
        t_uid        last_uid;
        bit          seen;
        t_result     expected [$];
        int unsigned errors;
        int unsigned frames;
        int unsigned match_count;

        function new();
            known[0] = nfcwm_pkg::KNOWN_A_RST;
            known[1] = nfcwm_pkg::KNOWN_B_RST;
            known[2] = nfcwm_pkg::KNOWN_C_RST;
            foreach (window[k]) window[k] = nfcwm_pkg::BYTE_ZERO;
            awake       = 1'b0;
            count       = 0;
            capture     = '0;
            last_uid    = '0;
            seen        = 1'b0;
            errors      = 0;
            frames      = 0;
            match_count = 0;
        endfunction

        function void set_known(logic [nfcwm_pkg::CFG_IDX_W-1:0] idx, t_uid data);
            if (idx <= nfcwm_pkg::CFG_KNOWN_C) known[idx] = data;
        endfunction

        function int unsigned pending();
            return expected.size();
        endfunction

        function int unsigned frame_pos();
            return count;
        endfunction

        function void note_byte(t_rx_byte b);
            t_result r;
            bit      head;
            int      rel;
            r = '0;
            if (!awake) begin
                for (int k = 0; k < nfcwm_pkg::WIN_DEPTH - 1; k++) window[k] = window[k + 1];
                window[nfcwm_pkg::WIN_DEPTH - 1] = b;
                head = window[0] == nfcwm_pkg::BYTE_ZERO && window[1] == nfcwm_pkg::BYTE_ZERO
                    && window[2] == nfcwm_pkg::BYTE_FF;
                if (head && ((window[3] == nfcwm_pkg::BYTE_ZERO &&
                              window[4] == nfcwm_pkg::BYTE_FF &&
                              window[5] == nfcwm_pkg::BYTE_ZERO) ||
                             (window[5] == nfcwm_pkg::BYTE_D5 &&
                              window[6] == nfcwm_pkg::BYTE_14)))
                    awake = 1'b1;
            end else begin
                rel = int'(count) - int'(nfcwm_pkg::UID_OFFSET_DEF);
                if (rel >= 0 && rel < 4) capture |= t_uid'(b) << (8 * (3 - rel));
                count++;
                if (count >= nfcwm_pkg::FRAME_LEN_DEF) begin
                    r.res.done    = 1'b1;
                    last_uid      = capture;
                    r.res.matched = capture == known[0] || capture == known[1] ||
                                    capture == known[2];
                    frames++;
                    if (r.res.matched) begin
                        seen = 1'b1;
                        match_count++;
                    end
                    capture = '0;
                    count   = 0;
                end
            end
            r.awake     = awake;
            r.res.seen  = seen;
            r.res.uid   = last_uid;
            expected.push_back(r);
        endfunction

        function void check_field(string name, t_uid want, t_uid got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected.size() == 0) begin
                $error("result word with no byte pending, card_uid %0h", got.res.uid);
                errors++;
                return;
            end
            want = expected.pop_front();
            check_field("awake", want.awake, got.awake);
            check_field("frame_done", want.res.done, got.res.done);
            check_field("frame_matched", want.res.matched, got.res.matched);
            check_field("card_seen", want.res.seen, got.res.seen);
            check_field("card_uid", want.res.uid, got.res.uid);
        endfunction
    endclass

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [nfcwm_pkg::CFG_IDX_W-1:0] i_cfg_index = nfcwm_pkg::CFG_KNOWN_A;
    t_uid                            i_cfg_data  = '0;
    logic                            i_valid     = 1'b0;
    t_rx_byte                        i_rx_byte   = nfcwm_pkg::BYTE_ZERO;
    logic                            i_ready     = 1'b0;
    logic                            o_ready;
    logic                            o_valid;
    logic                            o_awake;
    logic                            o_frame_done;
    logic                            o_frame_matched;
    logic                            o_card_seen;
    t_uid                            o_card_uid;

    uid_scoreboard sb;
    bit            steady       = 1'b0;
    int unsigned   sent         = 0;
    int unsigned   stall_cycles = 0;
    int unsigned   settings     = 0;
    string         wake_by      = "stray bytes";

    nfc_wake_and_card_uid_matcher i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_awake        (o_awake),
        .o_frame_done   (o_frame_done),
        .o_frame_matched(o_frame_matched),
        .o_card_seen    (o_card_seen),
        .o_card_uid     (o_card_uid)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(t_result'({o_awake, o_frame_done, o_frame_matched,
                                       o_card_seen, o_card_uid}));
        end
        i_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $error("no word moved for %0d cycles", STALL_LIMIT);
                $display("nfc_wake_and_card_uid_matcher verification failed");
                $finish;
            end
        end
    end

    function automatic t_rx_byte pick_byte();
        case ($urandom_range(7))
            0: return nfcwm_pkg::BYTE_ZERO;
            1: return nfcwm_pkg::BYTE_FF;
            2: return nfcwm_pkg::BYTE_D5;
            3: return nfcwm_pkg::BYTE_14;
            default: return t_rx_byte'($urandom);
        endcase
    endfunction

    task automatic send_byte(input t_rx_byte b);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_byte(b);
        sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic load_known(input t_uid a, input t_uid b, input t_uid c);
        logic [nfcwm_pkg::CFG_IDX_W-1:0] idx [4];
        t_uid                            val [4];
        idx = '{nfcwm_pkg::CFG_KNOWN_A, nfcwm_pkg::CFG_KNOWN_B, nfcwm_pkg::CFG_KNOWN_C,
                CFG_SPARE};
        val = '{a, b, c, t_uid'($urandom)};
        drain();
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            sb.set_known(idx[k], val[k]);
        end
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic send_wake_pattern(input bit resp, input bit broken);
        t_rx_byte    seq [7];
        int unsigned pos;
        if (resp) seq = '{nfcwm_pkg::BYTE_ZERO, nfcwm_pkg::BYTE_ZERO, nfcwm_pkg::BYTE_FF,
                          pick_byte(), pick_byte(), nfcwm_pkg::BYTE_D5, nfcwm_pkg::BYTE_14};
        else seq = '{nfcwm_pkg::BYTE_ZERO, nfcwm_pkg::BYTE_ZERO, nfcwm_pkg::BYTE_FF,
                     nfcwm_pkg::BYTE_ZERO, nfcwm_pkg::BYTE_FF, nfcwm_pkg::BYTE_ZERO,
                     pick_byte()};
        if (broken) begin
            pos = resp ? $urandom_range(0, 4) : $urandom_range(0, 5);
            if (resp && pos > 2) pos += 2;
            seq[pos] ^= t_rx_byte'($urandom_range(1, 255));
        end
        foreach (seq[k]) send_byte(seq[k]);
    endtask

    task automatic send_frame(input t_uid uid, input bit wake_fill);
        t_rx_byte b;
        int       rel;
        // finish a frame left open by loose bytes
        while (sb.frame_pos() != 0) send_byte(pick_byte());
        for (int p = 0; p < nfcwm_pkg::FRAME_LEN_DEF; p++) begin
            rel = p - int'(nfcwm_pkg::UID_OFFSET_DEF);
            if (rel >= 0 && rel < 4) b = uid[8 * (3 - rel) +: 8];
            else if (wake_fill) b = WAKE_FILL[p % 8];
            else b = pick_byte();
            send_byte(b);
        end
    endtask

    task automatic random_frame_step();
        int unsigned pick;
        t_uid        uid;
        pick = $urandom_range(99);
        if (pick < 15) begin
            repeat ($urandom_range(1, 30)) send_byte(pick_byte());
        end else begin
            if (pick < 55) uid = sb.known[$urandom_range(2)];
            else if (pick < 70)
                uid = sb.known[$urandom_range(2)] ^ (t_uid'(1) << $urandom_range(31));
            else uid = t_uid'($urandom);
            send_frame(uid, $urandom_range(9) == 0);
        end
    endtask

    initial begin
        bit          resp;
        int unsigned base;
        int unsigned phase_end;
        t_uid        same;
        sb   = new();
        resp = $urandom_range(1);
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_wake_pattern(1'b0, 1'b1);
        send_wake_pattern(1'b1, 1'b1);
        repeat (12) begin
            if (!sb.awake) begin
                if ($urandom_range(1)) send_wake_pattern($urandom_range(1), 1'b1);
                else repeat ($urandom_range(1, 8)) send_byte(pick_byte());
            end
        end
        if (!sb.awake) begin
            send_wake_pattern(resp, 1'b0);
            wake_by = resp ? "wake response" : "wake acknowledgement";
        end

        send_frame(nfcwm_pkg::KNOWN_A_RST ^ t_uid'(1), 1'b1);
        send_frame(nfcwm_pkg::KNOWN_B_RST, 1'b0);
        send_frame(nfcwm_pkg::KNOWN_C_RST, 1'b0);
        send_frame('0, 1'b0);
        send_frame('1, 1'b0);
        load_known('0, '1, nfcwm_pkg::KNOWN_A_RST);
        send_frame('0, 1'b0);
        send_frame('1, 1'b1);
        send_frame(nfcwm_pkg::KNOWN_A_RST, 1'b0);

        base = sent;
        for (int phase = 0; phase < PHASES; phase++) begin
            same = t_uid'($urandom);
            case (phase % 3)
                0: load_known(t_uid'($urandom), t_uid'($urandom), t_uid'($urandom));
                1: load_known(same, same, same);
                default: load_known('1, '0, same);
            endcase
            steady    = phase == 2;
            phase_end = base + (BYTE_TARGET - base) * (phase + 1) / PHASES;
            while (sent < phase_end) random_frame_step();
            steady = 1'b0;
        end

        drain();
        repeat (TAIL_CYC) @(posedge i_clk);
        $display("sent %0d bytes, woke by %s; %0d frames closed, %0d on a known card",
                 sent, wake_by, sb.frames, sb.match_count);
        $display("known identifiers loaded in %0d settings, zero and all-ones among them",
                 settings);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("nfc_wake_and_card_uid_matcher verification clean");
        end else begin
            $display("nfc_wake_and_card_uid_matcher verification failed");
        end
        $finish;
    end

endmodule
